// ===== src/ucht_pkg.sv =====
package ucht_pkg;

  localparam int DEVICE_SLOTS_DEF = 8;
  localparam int CLIENT_SLOTS_DEF = 8;

  typedef enum logic [3:0] {
    REQ_ENUM_START  = 4'd0,
    REQ_PORT_STATUS = 4'd1,
    REQ_OPEN        = 4'd2,
    REQ_CLOSE       = 4'd3,
    REQ_CONTROL     = 4'd4,
    REQ_BULK_IN     = 4'd5,
    REQ_BULK_OUT    = 4'd6,
    REQ_STATUS      = 4'd7,
    REQ_RESET       = 4'd8,
    REQ_INTERRUPT   = 4'd9
  } req_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_INDEX    = 3'd1,
    ST_NO_SLOTS     = 3'd2,
    ST_BAD_HANDLE   = 3'd3,
    ST_DISCONNECTED = 3'd4,
    ST_BAD_EP       = 3'd5,
    ST_STALL        = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    CFG_CONTROLLER_PRESENT = 1'b0,
    CFG_PORT_TOTAL         = 1'b1
  } cfg_index_t;

  localparam logic [1:0] SPD_FULL  = 2'd1;
  localparam logic [1:0] SPD_HIGH  = 2'd2;
  localparam logic [1:0] SPD_SUPER = 2'd3;

  localparam logic [3:0] PORT_SPD_HIGH  = 4'd3;
  localparam logic [3:0] PORT_SPD_SUPER = 4'd4;
  localparam int         PORT_SPD_LSB   = 10;

  localparam logic [7:0]  CLASS_NONE    = 8'h00;
  localparam logic [7:0]  CLASS_HID     = 8'h03;
  localparam logic [7:0]  CLASS_STORAGE = 8'h08;
  localparam logic [7:0]  CLASS_HUB     = 8'h09;
  localparam logic [7:0]  CLASS_VENDOR  = 8'hFF;
  localparam logic [31:0] POLICY_ALL    = 32'h0000_00FF;

  typedef struct packed {
    logic enum_start;
    logic enum_sim;
    logic append;
  } dev_cmd_t;

  typedef struct packed {
    logic open;
    logic close;
  } sess_cmd_t;

  typedef struct packed {
    logic hit;
    logic ep_ok;
    logic free_ok;
  } sess_info_t;

  function automatic logic [1:0] decode_speed(input logic [3:0] code);
    logic [1:0] spd;
    case (code)
      PORT_SPD_HIGH:  spd = SPD_HIGH;
      PORT_SPD_SUPER: spd = SPD_SUPER;
      default:        spd = SPD_FULL;
    endcase
    return spd;
  endfunction

  function automatic logic class_allowed(input logic [31:0] policy, input logic [7:0] cls);
    logic ok;
    if (policy == POLICY_ALL) begin
      ok = 1'b1;
    end else begin
      case (cls)
        CLASS_HID:     ok = policy[0];
        CLASS_STORAGE: ok = policy[1];
        CLASS_HUB:     ok = policy[2];
        CLASS_VENDOR:  ok = policy[3];
        default:       ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

// ===== src/ucht_in_if.sv =====
interface ucht_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [7:0]  port_number;
  logic [31:0] port_status;
  logic [31:0] device_index;
  logic [31:0] access_policy;
  logic [31:0] client_handle;
  logic [31:0] transfer_length;

  modport source (
    output valid, req_type, port_number, port_status, device_index,
           access_policy, client_handle, transfer_length,
    input  ready
  );

  modport sink (
    input  valid, req_type, port_number, port_status, device_index,
           access_policy, client_handle, transfer_length,
    output ready
  );
endinterface

// ===== src/ucht_out_if.sv =====
interface ucht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_code;
  logic [31:0] reply_value;
  logic        session_state;

  modport source (
    output valid, status_code, reply_value, session_state,
    input  ready
  );

  modport sink (
    input  valid, status_code, reply_value, session_state,
    output ready
  );
endinterface

// ===== src/ucht_dev_table.sv =====
module ucht_dev_table
  import ucht_pkg::*;
#(
  parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF,
  localparam int DIW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1,
  localparam int DCW = $clog2(DEVICE_SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dev_cmd_t       cmd,
  input  logic [1:0]     new_speed,
  input  logic [DIW-1:0] rd_addr,
  output logic [DCW-1:0] total,
  output logic [7:0]     rd_class,
  output logic [1:0]     rd_speed
);

  // A device entry is present exactly when its index is below the count.
  logic [7:0]     class_r [DEVICE_SLOTS];
  logic [1:0]     speed_r [DEVICE_SLOTS];
  logic [DCW-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        class_r[i] <= CLASS_NONE;
        speed_r[i] <= 2'd0;
      end
    end else if (cmd.enum_start) begin
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        class_r[i] <= CLASS_NONE;
        speed_r[i] <= 2'd0;
      end
      if (cmd.enum_sim) begin
        class_r[0] <= CLASS_HID;
        speed_r[0] <= SPD_HIGH;
        total_r    <= DCW'(1);
      end else begin
        total_r <= '0;
      end
    end else if (cmd.append) begin
      class_r[total_r[DIW-1:0]] <= CLASS_NONE;
      speed_r[total_r[DIW-1:0]] <= new_speed;
      total_r                   <= total_r + DCW'(1);
    end
  end

  assign total    = total_r;
  assign rd_class = class_r[rd_addr];
  assign rd_speed = speed_r[rd_addr];

endmodule

// ===== src/ucht_session.sv =====
module ucht_session
  import ucht_pkg::*;
#(
  parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF,
  parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
  localparam int DIW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1,
  localparam int CIW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sess_cmd_t      cmd,
  input  logic [31:0]    handle,
  input  logic [DIW-1:0] open_dev,
  input  logic           open_ep_ok,
  output sess_info_t     info,
  output logic [DIW-1:0] hit_dev,
  output logic [31:0]    issue_handle
);

  logic [CLIENT_SLOTS-1:0] active_r;
  logic [31:0]             handle_r [CLIENT_SLOTS];
  logic [DIW-1:0]          dev_r    [CLIENT_SLOTS];
  logic [CLIENT_SLOTS-1:0] ep_ok_r;
  logic [31:0]             counter_r;

  logic [CIW-1:0] hit_idx;
  logic [CIW-1:0] free_idx;
  logic           hit;
  logic           free_ok;

  // Lowest matching slot wins, and the lowest free slot is taken.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (active_r[i] && (handle_r[i] == handle)) begin
        hit     = 1'b1;
        hit_idx = CIW'(i);
      end
      if (!active_r[i]) begin
        free_ok  = 1'b1;
        free_idx = CIW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      counter_r <= 32'd1;
    end else begin
      if (cmd.open) begin
        active_r[free_idx] <= 1'b1;
        handle_r[free_idx] <= counter_r;
        dev_r[free_idx]    <= open_dev;
        ep_ok_r[free_idx]  <= open_ep_ok;
        counter_r          <= (counter_r == 32'hFFFF_FFFF) ? 32'd1 : counter_r + 32'd1;
      end
      if (cmd.close) begin
        active_r[hit_idx] <= 1'b0;
      end
    end
  end

  assign info.hit     = hit;
  assign info.ep_ok   = ep_ok_r[hit_idx];
  assign info.free_ok = free_ok;
  assign hit_dev      = dev_r[hit_idx];
  assign issue_handle = counter_r;

endmodule

// ===== src/usb_client_handle_table_core.sv =====
// Pipeline: a beat accepted into the input stage registers is decoded against the tables,
// and its result beat is registered and presented once the output register is free.
// Throughput: one beat per cycle when not stalled; table lookup and update set this rate.
// Reset (rst_n low at a clock edge, synchronous): device and session tables empty, handle
// counter at one, configuration registers zero, no beats held.
module usb_client_handle_table_core
  import ucht_pkg::*;
#(
  parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF,
  parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ucht_in_if.sink    in_ch,
  ucht_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int DIW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int DCW = $clog2(DEVICE_SLOTS + 1);

  logic       ctrl_present_r;
  logic [7:0] port_total_r;

  logic        s_valid_r;
  logic [3:0]  s_req_r;
  logic [7:0]  s_port_r;
  logic [31:0] s_pstat_r;
  logic [31:0] s_didx_r;
  logic [31:0] s_policy_r;
  logic [31:0] s_handle_r;
  logic [31:0] s_len_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_value_r;
  logic        out_sess_r;

  logic advance;
  logic in_ready;

  dev_cmd_t       dev_cmd;
  logic [DIW-1:0] rd_addr;
  logic [DCW-1:0] dev_total;
  logic [7:0]     rd_class;
  logic [1:0]     rd_speed;

  sess_cmd_t      sess_cmd;
  sess_info_t     sess_info;
  logic [DIW-1:0] hit_dev;
  logic [31:0]    issue_handle;

  status_t     status_nxt;
  logic [31:0] value_nxt;
  logic        sess_nxt;
  logic        enum_sim;
  logic        append_ok;
  logic        dev_full;
  logic        didx_ok;
  logic        hit_dev_here;

  assign advance     = s_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !s_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_present_r <= 1'b0;
      port_total_r   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CONTROLLER_PRESENT: ctrl_present_r <= cfg_data[0];
        CFG_PORT_TOTAL:         port_total_r   <= cfg_data;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s_req_r    <= in_ch.req_type;
      s_port_r   <= in_ch.port_number;
      s_pstat_r  <= in_ch.port_status;
      s_didx_r   <= in_ch.device_index;
      s_policy_r <= in_ch.access_policy;
      s_handle_r <= in_ch.client_handle;
      s_len_r    <= in_ch.transfer_length;
    end
  end

  assign enum_sim     = !ctrl_present_r || (port_total_r == 8'd0);
  assign dev_full     = (32'(dev_total) >= 32'(DEVICE_SLOTS));
  assign append_ok    = ctrl_present_r && (s_port_r < port_total_r)
                        && (32'(s_port_r) < 32'(DEVICE_SLOTS)) && s_pstat_r[0] && !dev_full;
  assign didx_ok      = (s_didx_r < 32'(dev_total)) && class_allowed(s_policy_r, rd_class);
  assign hit_dev_here = (32'(hit_dev) < 32'(dev_total));
  assign rd_addr      = (req_t'(s_req_r) == REQ_OPEN) ? s_didx_r[DIW-1:0] : hit_dev;

  always_comb begin
    status_nxt          = ST_OK;
    value_nxt           = 32'd0;
    sess_nxt            = 1'b0;
    dev_cmd.enum_start  = 1'b0;
    dev_cmd.enum_sim    = enum_sim;
    dev_cmd.append      = 1'b0;
    sess_cmd.open       = 1'b0;
    sess_cmd.close      = 1'b0;
    case (req_t'(s_req_r))
      REQ_ENUM_START: begin
        dev_cmd.enum_start = advance;
        value_nxt          = 32'(enum_sim);
      end
      REQ_PORT_STATUS: begin
        dev_cmd.append = advance && append_ok;
        value_nxt      = 32'(dev_total) + 32'(append_ok);
      end
      REQ_OPEN: begin
        if (!didx_ok) begin
          status_nxt = ST_BAD_INDEX;
        end else if (!sess_info.free_ok) begin
          status_nxt = ST_NO_SLOTS;
        end else begin
          value_nxt     = issue_handle;
          sess_cmd.open = advance;
        end
      end
      REQ_CLOSE: begin
        if (!sess_info.hit) begin
          status_nxt = ST_BAD_HANDLE;
        end else begin
          sess_cmd.close = advance;
        end
      end
      REQ_CONTROL, REQ_BULK_OUT: begin
        if (!sess_info.hit) begin
          status_nxt = ST_BAD_HANDLE;
        end else if (!hit_dev_here) begin
          status_nxt = ST_DISCONNECTED;
        end else begin
          value_nxt = s_len_r;
        end
      end
      REQ_BULK_IN: begin
        if (!sess_info.hit) begin
          status_nxt = ST_BAD_HANDLE;
        end else if (!hit_dev_here) begin
          status_nxt = ST_DISCONNECTED;
        end else if (!sess_info.ep_ok) begin
          status_nxt = ST_BAD_EP;
        end
      end
      REQ_STATUS: begin
        if (!sess_info.hit) begin
          status_nxt = ST_BAD_HANDLE;
          value_nxt  = 32'(SPD_FULL);
          sess_nxt   = 1'b1;
        end else begin
          value_nxt = 32'(rd_speed);
        end
      end
      REQ_RESET: begin
        if (!sess_info.hit) begin
          status_nxt = ST_BAD_HANDLE;
        end
      end
      default: begin
        status_nxt = ST_STALL;
      end
    endcase
  end

  ucht_dev_table #(
    .DEVICE_SLOTS(DEVICE_SLOTS)
  ) u_dev_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dev_cmd),
    .new_speed(decode_speed(s_pstat_r[PORT_SPD_LSB +: 4])),
    .rd_addr  (rd_addr),
    .total    (dev_total),
    .rd_class (rd_class),
    .rd_speed (rd_speed)
  );

  ucht_session #(
    .DEVICE_SLOTS(DEVICE_SLOTS),
    .CLIENT_SLOTS(CLIENT_SLOTS)
  ) u_session (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (sess_cmd),
    .handle      (s_handle_r),
    .open_dev    (s_didx_r[DIW-1:0]),
    .open_ep_ok  (s_policy_r[7:0] != 8'd0),
    .info        (sess_info),
    .hit_dev     (hit_dev),
    .issue_handle(issue_handle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
      out_sess_r   <= sess_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status_code   = out_status_r;
  assign out_ch.reply_value   = out_value_r;
  assign out_ch.session_state = out_sess_r;

endmodule
